[src/ulv_pkg.sv]
// shared types and constants for the utf-8 label validator
package ulv_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd32;
  localparam logic [BYTE_W-1:0] COUNT_SAT     = 8'hff;
  localparam logic [BYTE_W-1:0] MIN_PRINTABLE = 8'h20;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT   = 8'h80;

  localparam logic [CP_W-1:0] CP_MIN_2BYTE  = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3BYTE  = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4BYTE  = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX        = 21'h10ffff;
  localparam logic [CP_W-1:0] SURROGATE_LO  = 21'h00d800;
  localparam logic [CP_W-1:0] SURROGATE_HI  = 21'h00dfff;

  // continuation counts of a sequence
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // one accepted input request
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              is_last;
  } ulv_item_t;

  // running decode state of one string
  typedef struct packed {
    logic [1:0]        pending;
    logic [1:0]        seq_len;
    logic [CP_W-1:0]   acc;
    logic              failed;
    logic [BYTE_W-1:0] count;
  } ulv_state_t;

  localparam ulv_state_t STATE_CLEAR = '0;

endpackage

[src/ulv_if.sv]
// request channels of the utf-8 label validator
interface ulv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       is_last;
  modport source (output valid, data_byte, byte_present, is_last, input ready);
  modport sink   (input valid, data_byte, byte_present, is_last, output ready);
endinterface

interface ulv_result_if;
  logic valid;
  logic ready;
  logic string_ok;
  modport source (output valid, string_ok, input ready);
  modport sink   (input valid, string_ok, output ready);
endinterface

interface ulv_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_label_length;
  modport source (output valid, max_label_length, input ready);
  modport sink   (input valid, max_label_length, output ready);
endinterface

[src/ulv_in_reg.sv]
// input register stage for byte requests
module ulv_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  ulv_byte_if.sink          in_if,
  input  logic              take_i,
  output ulv_pkg::ulv_item_t item_o,
  output logic              valid_o
);
  import ulv_pkg::*;

  logic      valid_r;
  ulv_item_t item_r;

  // room when empty or when the held request moves on this cycle
  assign in_if.ready = !valid_r || take_i;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.data_byte    <= in_if.data_byte;
      item_r.byte_present <= in_if.byte_present;
      item_r.is_last      <= in_if.is_last;
    end
  end

  assign item_o  = item_r;
  assign valid_o = valid_r;

endmodule

[src/ulv_decode.sv]
// next decode state and verdict for one byte request
module ulv_decode (
  input  ulv_pkg::ulv_state_t state_i,
  input  ulv_pkg::ulv_item_t  item_i,
  input  logic [7:0]          max_len_i,
  output ulv_pkg::ulv_state_t state_o,
  output logic                ok_o
);
  import ulv_pkg::*;

  ulv_state_t        s;
  logic [BYTE_W-1:0] c;
  logic [CP_W-1:0]   cp;

  always_comb begin
    s  = state_i;
    c  = item_i.data_byte;
    cp = {state_i.acc[CP_W-7:0], c[5:0]};

    if (item_i.byte_present) begin
      // length limit and saturating count
      if (state_i.count >= max_len_i) s.failed = 1'b1;
      if (state_i.count != COUNT_SAT) s.count = state_i.count + 8'd1;

      if (!s.failed) begin
        if (state_i.pending == SEQ_NONE) begin
          // lead byte
          priority if (c < MIN_PRINTABLE) begin
            s.failed = 1'b1;
          end else if (c < ASCII_LIMIT) begin
            s.failed = 1'b0;
          end else if (c[7:5] == 3'b110) begin
            s.acc     = {16'd0, c[4:0]};
            s.seq_len = SEQ_TWO;
            s.pending = SEQ_TWO;
          end else if (c[7:4] == 4'b1110) begin
            s.acc     = {17'd0, c[3:0]};
            s.seq_len = SEQ_THREE;
            s.pending = SEQ_THREE;
          end else if (c[7:3] == 5'b11110) begin
            s.acc     = {18'd0, c[2:0]};
            s.seq_len = SEQ_FOUR;
            s.pending = SEQ_FOUR;
          end else begin
            s.failed = 1'b1;
          end
        end else if (c[7:6] != 2'b10) begin
          // continuation expected
          s.failed = 1'b1;
        end else begin
          s.acc     = cp;
          s.pending = state_i.pending - 2'd1;
          // sequence complete: overlong, range and surrogate checks
          if (state_i.pending == SEQ_TWO) begin
            if (state_i.seq_len == SEQ_TWO   && cp < CP_MIN_2BYTE) s.failed = 1'b1;
            if (state_i.seq_len == SEQ_THREE && cp < CP_MIN_3BYTE) s.failed = 1'b1;
            if (state_i.seq_len == SEQ_FOUR  && cp < CP_MIN_4BYTE) s.failed = 1'b1;
            if (cp > CP_MAX) s.failed = 1'b1;
            if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) s.failed = 1'b1;
          end
        end
      end
    end

    ok_o = !s.failed && (s.pending == SEQ_NONE);

    // end of string clears everything
    state_o = item_i.is_last ? STATE_CLEAR : s;
  end

endmodule

[src/utf8_label_validator_top.sv]
// top level of the streaming utf-8 label validator
//
//  channel  | dir | payload                               | handshake
//  ---------+-----+---------------------------------------+--------------
//  in_if    | in  | data_byte[7:0], byte_present, is_last | valid / ready
//  out_if   | out | string_ok                             | valid / ready
//  cfg_if   | in  | max_label_length[7:0]                 | valid / ready
//
// one byte request per cycle while no last-marked request waits on a stalled result; a
// verdict passes through the input register, then the result register
// synchronous active-low reset clears decode state, sets the limit to 32
// a stalled result holds only last-marked requests; others keep flowing
// cfg_if is always ready; the user must make writes while the block is idle, as the block does not enforce this
module utf8_label_validator_top (
  input  logic        clk,
  input  logic        rst_n,
  ulv_byte_if.sink    in_if,
  ulv_result_if.source out_if,
  ulv_cfg_if.sink     cfg_if
);
  import ulv_pkg::*;

  ulv_item_t         item;
  logic              item_valid;
  logic              proc_fire;
  ulv_state_t        state_r;
  ulv_state_t        state_nxt;
  logic              dec_ok;
  logic [BYTE_W-1:0] max_len_r;
  logic              out_valid_r;
  logic              out_ok_r;

  // held request advances unless it needs a result slot that is still full
  assign proc_fire = item_valid && (!item.is_last || !out_valid_r || out_if.ready);

  ulv_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .take_i  (proc_fire),
    .item_o  (item),
    .valid_o (item_valid)
  );

  ulv_decode u_dec (
    .state_i   (state_r),
    .item_i    (item),
    .max_len_i (max_len_r),
    .state_o   (state_nxt),
    .ok_o      (dec_ok)
  );

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  // length limit register
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_if.valid) begin
      max_len_r <= cfg_if.max_label_length;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && item.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && item.is_last) begin
      out_ok_r <= dec_ok;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.string_ok = out_ok_r;

endmodule

[dv/utf8_label_validator_top_test.sv]
// self-checking testbench of the streaming utf-8 label validator
`timescale 1ns / 100ps

module utf8_label_validator_top_test;
  import ulv_pkg::*;

  // flaws planted in malformed labels
  typedef enum int unsigned {
    FLAW_CONTROL,
    FLAW_LEAD,
    FLAW_CONT,
    FLAW_OVERLONG,
    FLAW_SURROGATE,
    FLAW_RANGE,
    FLAW_TRUNC
  } flaw_t;

  // label decoder copy and queue of expected verdicts
  class label_scoreboard;
    ulv_state_t        st;
    logic [BYTE_W-1:0] max_len;
    logic              verdict_q[$];
    int unsigned       errors;

    function new();
      st = STATE_CLEAR;
      max_len = MAX_LEN_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [BYTE_W-1:0] v);
      max_len = v;
    endfunction

    // advance the decoder by one accepted request
    function void note_request(ulv_item_t it);
      if (it.byte_present) begin
        if (st.count >= max_len) st.failed = 1'b1;
        if (st.count != COUNT_SAT) st.count = st.count + 1'b1;
        if (!st.failed) begin
          if (st.pending == SEQ_NONE) begin
            // lead byte or plain ascii
            if (it.data_byte < MIN_PRINTABLE) begin
              st.failed = 1'b1;
            end else if (it.data_byte >= ASCII_LIMIT) begin
              casez (it.data_byte)
                8'b110?_???? : begin
                  st.acc = {16'd0, it.data_byte[4:0]};
                  st.seq_len = SEQ_TWO;
                end
                8'b1110_???? : begin
                  st.acc = {17'd0, it.data_byte[3:0]};
                  st.seq_len = SEQ_THREE;
                end
                8'b1111_0??? : begin
                  st.acc = {18'd0, it.data_byte[2:0]};
                  st.seq_len = SEQ_FOUR;
                end
                default: st.failed = 1'b1;
              endcase
              if (!st.failed) st.pending = st.seq_len;
            end
          end else if (it.data_byte[7:6] != 2'b10) begin
            st.failed = 1'b1;
          end else begin
            // continuation byte, check the code point once complete
            st.acc = {st.acc[CP_W-7:0], it.data_byte[5:0]};
            st.pending = st.pending - 1'b1;
            if (st.pending == SEQ_NONE) begin
              if ((st.seq_len == SEQ_TWO && st.acc < CP_MIN_2BYTE) ||
                  (st.seq_len == SEQ_THREE && st.acc < CP_MIN_3BYTE) ||
                  (st.seq_len == SEQ_FOUR && st.acc < CP_MIN_4BYTE) ||
                  (st.acc > CP_MAX) ||
                  (st.acc >= SURROGATE_LO && st.acc <= SURROGATE_HI))
                st.failed = 1'b1;
            end
          end
        end
      end
      if (it.is_last) begin
        verdict_q.push_back(!st.failed && st.pending == SEQ_NONE);
        st = STATE_CLEAR;
      end
    endfunction

    function void check_result(logic ok);
      logic want;
      if (verdict_q.size() == 0) begin
        $error("string_ok: expected none, actual %0b", ok);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (ok !== want) begin
          $error("string_ok: expected %0b, actual %0b", want, ok);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ulv_byte_if   in_if ();
  ulv_result_if out_if ();
  ulv_cfg_if    cfg_if ();

  utf8_label_validator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  label_scoreboard sb = new();

  logic [7:0]  label_q[$];
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold      = 1'b0;
  int unsigned items_sent   = 0;

  always #10 clk = ~clk;

  // run limit
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random back-pressure plus long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = !rx_hold && ($urandom_range(99) >= rx_stall_pct);
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.string_ok);
    end
  end

  // one byte request, preceded by a random idle gap
  task automatic push_request(logic [7:0] b, logic present, logic last);
    ulv_item_t it;
    it.data_byte = b;
    it.byte_present = present;
    it.is_last = last;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.data_byte = b;
    in_if.byte_present = present;
    in_if.is_last = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_request(it);
    if (present || last) items_sent++;
  endtask

  // drop valid, wait for all verdicts and for the pipeline to empty
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.max_label_length = v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_limit(v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // send label_q, ended on its last byte, by an empty marker, or left open
  task automatic send_label(bit marker_end, bit leave_open);
    for (int i = 0; i < label_q.size(); i++) begin
      if ($urandom_range(19) == 0) push_request(8'($urandom), 1'b0, 1'b0);
      push_request(label_q[i], 1'b1,
                   !marker_end && !leave_open && i == label_q.size() - 1);
    end
    if (!leave_open && (marker_end || label_q.size() == 0))
      push_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // encode a code point in nbytes bytes, minimal or not
  function automatic void add_encoded(logic [20:0] cp, int unsigned nbytes);
    case (nbytes)
      1: label_q.push_back({1'b0, cp[6:0]});
      2: begin
        label_q.push_back({3'b110, cp[10:6]});
        label_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        label_q.push_back({4'b1110, cp[15:12]});
        label_q.push_back({2'b10, cp[11:6]});
        label_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        label_q.push_back({5'b11110, cp[20:18]});
        label_q.push_back({2'b10, cp[17:12]});
        label_q.push_back({2'b10, cp[11:6]});
        label_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic int unsigned min_bytes(logic [20:0] cp);
    if (cp < CP_MIN_2BYTE) return 1;
    if (cp < CP_MIN_3BYTE) return 2;
    if (cp < CP_MIN_4BYTE) return 3;
    return 4;
  endfunction

  // random label: mostly well-formed, some flawed, some noise or near the limit
  task automatic random_label();
    int unsigned n;
    int unsigned pick;
    int unsigned bad_at;
    int unsigned k;
    bit          bad;
    flaw_t       flaw;
    logic [20:0] cp;
    label_q.delete();
    pick = $urandom_range(99);
    if (pick < 4) begin
      // length around the limit
      n = sb.max_len + $urandom_range(2);
      if (n > 0) n--;
      while (label_q.size() < n) label_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end else if (pick < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) label_q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 6);
      bad = pick < 45;
      flaw = flaw_t'($urandom_range(0, FLAW_TRUNC));
      bad_at = $urandom_range(0, n);
      for (int i = 0; i <= n; i++) begin
        if (bad && i == bad_at && flaw != FLAW_TRUNC) begin
          case (flaw)
            FLAW_CONTROL: label_q.push_back(8'($urandom_range(0, 8'h1f)));
            FLAW_LEAD:
              label_q.push_back(8'($urandom_range(1) ? $urandom_range(8'h80, 8'hbf)
                                                     : $urandom_range(8'hf8, 8'hff)));
            FLAW_CONT: begin
              label_q.push_back(8'($urandom_range(8'hc2, 8'hf4)));
              label_q.push_back(8'($urandom_range(1) ? $urandom_range(0, 8'h7f)
                                                     : $urandom_range(8'hc0, 8'hff)));
            end
            FLAW_OVERLONG: begin
              k = $urandom_range(2, 4);
              case (k)
                2: add_encoded(21'($urandom_range(0, 8'h7f)), 2);
                3: add_encoded(21'($urandom_range(0, 12'h7ff)), 3);
                default: add_encoded(21'($urandom_range(0, 16'hffff)), 4);
              endcase
            end
            FLAW_SURROGATE:
              add_encoded(21'($urandom_range(SURROGATE_LO, SURROGATE_HI)), 3);
            default: add_encoded(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
          endcase
        end else if (i < n) begin
          // well-formed character, boundaries now and then
          case ($urandom_range(9))
            0, 1, 2, 3: cp = 21'($urandom_range(8'h20, 8'h7f));
            4, 5: cp = 21'($urandom_range(12'h080, 12'h7ff));
            6, 7: begin
              cp = 21'($urandom_range(16'h0800, 16'hffff));
              if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp ^ 21'h4000;
            end
            8: cp = 21'($urandom_range(CP_MIN_4BYTE, CP_MAX));
            default: begin
              case ($urandom_range(8))
                0: cp = 21'h7f;
                1: cp = CP_MIN_2BYTE;
                2: cp = 21'h7ff;
                3: cp = CP_MIN_3BYTE;
                4: cp = SURROGATE_LO - 1;
                5: cp = SURROGATE_HI + 1;
                6: cp = 21'hffff;
                7: cp = CP_MIN_4BYTE;
                default: cp = CP_MAX;
              endcase
            end
          endcase
          add_encoded(cp, min_bytes(cp));
        end
      end
      if (bad && flaw == FLAW_TRUNC) begin
        // multi-byte character cut short at the end
        cp = 21'($urandom_range(CP_MIN_2BYTE, CP_MAX));
        if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp ^ 21'h4000;
        k = min_bytes(cp);
        add_encoded(cp, k);
        repeat ($urandom_range(1, k - 1)) void'(label_q.pop_back());
      end
    end
    send_label($urandom_range(4) == 0, 1'b0);
  endtask

  initial begin
    int unsigned phase_end;
    bit          paused;
    logic [7:0]  limits[8];

    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.byte_present = 1'b0;
    in_if.is_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_label_length = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed labels at the reset limit
    label_q.delete();
    send_label(1'b1, 1'b0);
    label_q = '{8'h41};                      send_label(1'b0, 1'b0);
    label_q = '{8'h20};                      send_label(1'b0, 1'b0);
    label_q = '{8'h1f};                      send_label(1'b0, 1'b0);
    label_q = '{8'h00};                      send_label(1'b0, 1'b0);
    label_q = '{8'h7f};                      send_label(1'b0, 1'b0);
    label_q = '{8'hc3, 8'ha9};               send_label(1'b0, 1'b0);
    label_q = '{8'hc0, 8'h80};               send_label(1'b0, 1'b0);
    label_q = '{8'hed, 8'ha0, 8'h80};        send_label(1'b0, 1'b0);
    label_q = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_label(1'b0, 1'b0);
    label_q = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; send_label(1'b0, 1'b0);
    label_q = '{8'hff};                      send_label(1'b0, 1'b0);
    label_q = '{8'he2, 8'h82};               send_label(1'b1, 1'b0);
    label_q = '{8'hc3, 8'h41};               send_label(1'b0, 1'b0);
    push_request(8'ha5, 1'b0, 1'b0);
    label_q = '{8'h42};                      send_label(1'b0, 1'b0);

    // random phases, each with its own limit and one of four idle patterns
    limits = '{MAX_LEN_RESET, 8'd0, 8'd255, 8'd1, 8'($urandom), 8'd8, 8'($urandom), 8'd3};
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph > 0) write_limit(limits[ph]);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
      endcase
      phase_end = items_sent + 225;
      paused = 1'b0;
      if (ph == 2) begin
        // long result hold-off while short labels keep coming
        fork
          begin
            @(posedge clk);
            rx_hold = 1'b1;
            repeat (200) @(posedge clk);
            rx_hold = 1'b0;
          end
          repeat (40) begin
            label_q = '{8'($urandom_range(8'h20, 8'h7f))};
            send_label(1'b0, 1'b0);
          end
        join
      end
      while (items_sent < phase_end) begin
        if (!paused && items_sent >= phase_end - 110) begin
          settle();
          paused = 1'b1;
        end
        random_label();
      end
    end

    // limit changed in the middle of a label, lowered then raised
    settle();
    write_limit(8'd4);
    label_q = '{8'h41, 8'h42, 8'h43};
    send_label(1'b0, 1'b1);
    settle();
    write_limit(8'd2);
    label_q = '{8'h44};
    send_label(1'b0, 1'b0);
    label_q = '{8'h45, 8'h46};
    send_label(1'b0, 1'b1);
    settle();
    write_limit(8'd5);
    label_q = '{8'h47, 8'h48};
    send_label(1'b0, 1'b0);

    settle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
